[hw/rtl/hfq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hfq_pkg;

  localparam int COORD_W   = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int POINT_W   = 8;
  localparam int HEIGHT_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE = 2'd2;

  localparam logic [CFG_W-1:0] GRID_SCALE_RESET = 24'h010000;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_MISS
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_FIN
  } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/heightfield_triangle_height_query_core.sv]
// Writes pass through the front register and the queue to the grid store; they return no result.
// A query that falls outside the grid returns in_range low and a zero height without reading the grid;
// one inside reads its three corners in turn through one memory port and returns their weighted sum.
// The front accepts one transaction per cycle until the queue fills; the back end takes no new entry
// while a query is in flight. The result strobe done is high for one cycle and cannot be held off.
// Synchronous reset restores config and control registers; the height grid is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_triangle_height_query_core #(
  parameter int GRID_POINTS   = 256,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   world_x,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   world_z,
  input  wire logic [hfq_pkg::POINT_W-1:0]          point_x,
  input  wire logic [hfq_pkg::POINT_W-1:0]          point_z,
  input  wire logic signed [hfq_pkg::HEIGHT_W-1:0]  point_height,
  output logic                                      done,
  output logic signed [hfq_pkg::HEIGHT_W-1:0]       height,
  output logic                                      in_range,
  input  wire logic                                 cfg_write,
  input  wire logic [hfq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [hfq_pkg::CFG_W-1:0]            cfg_data
);

  import hfq_pkg::*;

  localparam int CW      = $clog2(GRID_POINTS);
  localparam int ENTRY_W = $bits(op_t) + 2 * CW + 2 * FRACTION_BITS + HEIGHT_W;

  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_z;
  logic [CFG_W-1:0]          grid_scale;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_full;
  logic               pop;
  logic [ENTRY_W-1:0] q_data;
  logic               q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_z   <= '0;
      grid_scale <= GRID_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:   origin_x   <= cfg_data;
        CFG_ORIGIN_Z:   origin_z   <= cfg_data;
        CFG_GRID_SCALE: grid_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  hfq_front #(
    .GRID_POINTS  (GRID_POINTS),
    .FRACTION_BITS(FRACTION_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .world_x     (world_x),
    .world_z     (world_z),
    .point_x     (point_x),
    .point_z     (point_z),
    .point_height(point_height),
    .origin_x    (origin_x),
    .origin_z    (origin_z),
    .grid_scale  (grid_scale),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  hfq_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_data),
    .empty    (q_empty)
  );

  hfq_back #(
    .GRID_POINTS  (GRID_POINTS),
    .FRACTION_BITS(FRACTION_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .pop     (pop),
    .done    (done),
    .height  (height),
    .in_range(in_range)
  );

endmodule

`default_nettype wire

[hw/rtl/hfq_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfq_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hfq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfq_front #(
  parameter int GRID_POINTS   = 256,
  parameter int FRACTION_BITS = 8,
  parameter int ENTRY_W       = 50
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   world_x,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   world_z,
  input  wire logic [hfq_pkg::POINT_W-1:0]          point_x,
  input  wire logic [hfq_pkg::POINT_W-1:0]          point_z,
  input  wire logic signed [hfq_pkg::HEIGHT_W-1:0]  point_height,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   origin_x,
  input  wire logic signed [hfq_pkg::COORD_W-1:0]   origin_z,
  input  wire logic [hfq_pkg::CFG_W-1:0]            grid_scale,
  input  wire logic                                 q_full,
  output logic                                      push,
  output logic [ENTRY_W-1:0]                        push_data
);

  import hfq_pkg::*;

  localparam int CW = $clog2(GRID_POINTS);
  localparam int FB = FRACTION_BITS;
  localparam int TW = COORD_W + 1;
  localparam int PW = 2 * TW;

  logic                       f_valid;
  logic                       f_query;
  logic signed [TW-1:0]       t_x;
  logic signed [TW-1:0]       t_z;
  logic [POINT_W-1:0]         px;
  logic [POINT_W-1:0]         pz;
  logic signed [HEIGHT_W-1:0] ph;

  logic signed [PW-1:0] p_x;
  logic signed [PW-1:0] p_z;
  logic [31:0]          px_wide;
  logic [31:0]          pz_wide;
  logic                 wr_ok;
  logic                 hit_x;
  logic                 hit_z;
  logic                 drop;
  logic                 consume;
  logic                 accept;
  op_t                  op;
  logic [CW-1:0]        cell_x;
  logic [CW-1:0]        cell_z;

  assign p_x = t_x * $signed({1'b0, grid_scale});
  assign p_z = t_z * $signed({1'b0, grid_scale});

  assign px_wide = {24'd0, px};
  assign pz_wide = {24'd0, pz};
  assign wr_ok   = (px_wide < 32'(GRID_POINTS)) && (pz_wide < 32'(GRID_POINTS));

  assign hit_x = !p_x[PW-1] && (p_x[47:24] < 24'(GRID_POINTS - 1));
  assign hit_z = !p_z[PW-1] && (p_z[47:24] < 24'(GRID_POINTS - 1));

  assign drop    = f_valid && !f_query && !wr_ok;
  assign push    = f_valid && !q_full && !drop;
  assign consume = f_valid && (drop || !q_full);
  assign busy    = f_valid && !consume;
  assign accept  = start && !busy;

  always_comb begin
    if (!f_query) begin
      op     = OP_WRITE;
      cell_x = px_wide[CW-1:0];
      cell_z = pz_wide[CW-1:0];
    end else begin
      op     = (hit_x && hit_z) ? OP_QUERY : OP_MISS;
      cell_x = p_x[24 +: CW];
      cell_z = p_z[24 +: CW];
    end
  end

  assign push_data = {op, cell_z, cell_x, p_z[24-FB +: FB], p_x[24-FB +: FB], ph};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (consume) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_query <= action;
      t_x     <= $signed({world_x[COORD_W-1], world_x}) - $signed({origin_x[COORD_W-1], origin_x});
      t_z     <= $signed({world_z[COORD_W-1], world_z}) - $signed({origin_z[COORD_W-1], origin_z});
      px      <= point_x;
      pz      <= point_z;
      ph      <= point_height;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hfq_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfq_back #(
  parameter int GRID_POINTS   = 256,
  parameter int FRACTION_BITS = 8,
  parameter int ENTRY_W       = 50
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_empty,
  input  wire logic [ENTRY_W-1:0]                  q_data,
  output logic                                     pop,
  output logic                                     done,
  output logic signed [hfq_pkg::HEIGHT_W-1:0]      height,
  output logic                                     in_range
);

  import hfq_pkg::*;

  localparam int CW     = $clog2(GRID_POINTS);
  localparam int FB     = FRACTION_BITS;
  localparam int AW     = 2 * CW;
  localparam int DEPTH  = 1 << AW;
  localparam int OPW    = $bits(op_t);
  localparam int ACC_W  = HEIGHT_W + FB + 2;
  localparam int ONE_I  = 1 << FB;
  localparam logic [FB:0] ONE = ONE_I[FB:0];
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(ONE_I / 2);

  logic signed [HEIGHT_W-1:0] mem [DEPTH];

  back_state_t state;
  back_state_t state_next;

  op_t                        e_op;
  logic [CW-1:0]              e_cz;
  logic [CW-1:0]              e_cx;
  logic [FB-1:0]              e_fz;
  logic [FB-1:0]              e_fx;
  logic signed [HEIGHT_W-1:0] e_data;

  logic [FB:0]   fsum;
  logic          lower;
  logic [CW-1:0] cx1;
  logic [CW-1:0] cz1;
  logic [FB:0]   wa_in;
  logic [FB:0]   wb_in;
  logic [FB:0]   wc_in;

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] addr_c;
  logic [FB:0]   w_a;
  logic [FB:0]   w_b;
  logic [FB:0]   w_c;
  logic [1:0]    cnt;

  logic [AW-1:0] raddr;
  logic [FB:0]   rw;
  logic          mem_we;
  logic          latch;
  logic          out_fire;
  logic          out_hit;

  logic signed [HEIGHT_W-1:0] rdata;
  logic                       mac_en;
  logic                       mac_first;
  logic [FB:0]                mac_w;
  logic signed [ACC_W-1:0]    prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rounded;

  assign e_op   = op_t'(q_data[ENTRY_W-1 -: OPW]);
  assign e_cz   = q_data[HEIGHT_W + 2*FB + CW +: CW];
  assign e_cx   = q_data[HEIGHT_W + 2*FB +: CW];
  assign e_fz   = q_data[HEIGHT_W + FB +: FB];
  assign e_fx   = q_data[HEIGHT_W +: FB];
  assign e_data = q_data[HEIGHT_W-1:0];

  assign fsum  = {1'b0, e_fx} + {1'b0, e_fz};
  assign lower = (fsum <= ONE);
  assign cx1   = e_cx + CW'(1);
  assign cz1   = e_cz + CW'(1);

  always_comb begin
    if (lower) begin
      wa_in = {1'b0, e_fx};
      wb_in = {1'b0, e_fz};
      wc_in = ONE - fsum;
    end else begin
      wa_in = ONE - {1'b0, e_fz};
      wb_in = ONE - {1'b0, e_fx};
      wc_in = fsum - ONE;
    end
  end

  always_comb begin
    unique case (cnt)
      2'd0: begin
        raddr = addr_a;
        rw    = w_a;
      end
      2'd1: begin
        raddr = addr_b;
        rw    = w_b;
      end
      default: begin
        raddr = addr_c;
        rw    = w_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    latch      = 1'b0;
    out_fire   = 1'b0;
    out_hit    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (e_op)
            OP_WRITE: mem_we = 1'b1;
            OP_QUERY: begin
              latch      = 1'b1;
              state_next = BK_READ;
            end
            default: out_fire = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        if (cnt == 2'd2) begin
          state_next = BK_WAIT;
        end
      end
      BK_WAIT: state_next = BK_FIN;
      BK_FIN: begin
        out_fire   = 1'b1;
        out_hit    = 1'b1;
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{e_cz, e_cx}] <= e_data;
    end
    rdata <= mem[raddr];
  end

  assign prod = rdata * $signed({1'b0, mac_w});

  always_ff @(posedge clk) begin
    if (latch) begin
      addr_a <= {e_cz, cx1};
      addr_b <= {cz1, e_cx};
      addr_c <= lower ? {e_cz, e_cx} : {cz1, cx1};
      w_a    <= wa_in;
      w_b    <= wb_in;
      w_c    <= wc_in;
    end
    mac_w     <= rw;
    mac_first <= (cnt == 2'd0);
    if (mac_en) begin
      acc <= (mac_first ? '0 : acc) + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      mac_en <= 1'b0;
    end else begin
      mac_en <= (state == BK_READ);
      if (state == BK_READ) begin
        cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
      end
    end
  end

  assign rounded = acc + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      height   <= out_hit ? rounded[FB +: HEIGHT_W] : '0;
      in_range <= out_hit;
    end
  end

endmodule

`default_nettype wire

[tb/heightfield_triangle_height_query_core_test.sv]
`timescale 1ns / 1ps

module heightfield_triangle_height_query_core_test;
  import hfq_pkg::*;

  localparam int GRID_N = 256;
  localparam int FRAC_N = 8;
  localparam int ONE = 1 << FRAC_N;
  localparam int SCALE_FRAC = 24;
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic                       act;
    logic signed [COORD_W-1:0]  wx;
    logic signed [COORD_W-1:0]  wz;
    logic [POINT_W-1:0]         px;
    logic [POINT_W-1:0]         pz;
    logic signed [HEIGHT_W-1:0] ph;
  } hq_item_t;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       in_range;
  } hq_result_t;

  typedef struct {
    hq_item_t   item;
    bit         fixed;
    hq_result_t res;
  } hq_vector_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       action = ACT_WRITE;
  logic signed [COORD_W-1:0]  world_x = '0;
  logic signed [COORD_W-1:0]  world_z = '0;
  logic [POINT_W-1:0]         point_x = '0;
  logic [POINT_W-1:0]         point_z = '0;
  logic signed [HEIGHT_W-1:0] point_height = '0;
  logic                       done;
  logic signed [HEIGHT_W-1:0] height;
  logic                       in_range;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_ORIGIN_X;
  logic [CFG_W-1:0]           cfg_data = '0;

  logic signed [COORD_W-1:0]  cur_origin_x = '0;
  logic signed [COORD_W-1:0]  cur_origin_z = '0;
  logic [CFG_W-1:0]           cur_scale = GRID_SCALE_RESET;
  logic signed [HEIGHT_W-1:0] height_grid [0:GRID_N*GRID_N-1];
  bit                         point_written [0:GRID_N*GRID_N-1];
  hq_result_t                 expected_heights [$];
  hq_vector_t                 directed_vectors [$];
  int                         error_count = 0;
  int                         burst_left = 0;

  heightfield_triangle_height_query_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .world_x(world_x), .world_z(world_z), .point_x(point_x), .point_z(point_z),
    .point_height(point_height), .done(done), .height(height), .in_range(in_range),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit locate_cell(input logic signed [COORD_W-1:0] w,
                                     input logic signed [COORD_W-1:0] org,
                                     output int unsigned cell_idx, output int frac);
    longint t;
    longint p;
    t = longint'(w) - longint'(org);
    p = t * longint'({40'd0, cur_scale});
    cell_idx = 0;
    frac = 0;
    if (p < 0) return 1'b0;
    if ((p >>> SCALE_FRAC) >= longint'(GRID_N - 1)) return 1'b0;
    cell_idx = int'(p >>> SCALE_FRAC);
    frac = int'((p >>> (SCALE_FRAC - FRAC_N)) & longint'(ONE - 1));
    return 1'b1;
  endfunction

  function automatic hq_result_t interpolate_height(input logic signed [COORD_W-1:0] wx,
                                                    input logic signed [COORD_W-1:0] wz);
    hq_result_t res;
    int unsigned cx, cz;
    int fx, fz;
    bit okx, okz;
    longint h00, h10, h01, h11, acc;
    res.height = '0;
    res.in_range = 1'b0;
    okx = locate_cell(wx, cur_origin_x, cx, fx);
    okz = locate_cell(wz, cur_origin_z, cz, fz);
    if (!(okx && okz)) return res;
    h00 = height_grid[cx + cz * GRID_N];
    h10 = height_grid[cx + 1 + cz * GRID_N];
    h01 = height_grid[cx + (cz + 1) * GRID_N];
    h11 = height_grid[cx + 1 + (cz + 1) * GRID_N];
    if (fx + fz <= ONE)
      acc = h00 * (ONE - fx - fz) + h10 * fx + h01 * fz;
    else
      acc = h10 * (ONE - fz) + h11 * (fx + fz - ONE) + h01 * (ONE - fx);
    acc = ((acc + 32768 * ONE + ONE / 2) >>> FRAC_N) - 32768;
    res.height = acc[HEIGHT_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] aim_axis(input logic [COORD_W-1:0] org);
    longint p, t;
    int unsigned c, pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) c = $urandom_range(0, 7);
    else if (pick < 75) c = $urandom_range(GRID_N - 3, GRID_N - 1);
    else c = $urandom_range(0, GRID_N - 1);
    p = (longint'(c) << SCALE_FRAC) + (longint'($urandom_range(0, ONE - 1)) << 16)
      + longint'($urandom_range(0, 65535));
    if (cur_scale == '0) t = longint'($urandom_range(0, 255));
    else t = p / longint'({40'd0, cur_scale});
    return org + t[COORD_W-1:0];
  endfunction

  function automatic hq_vector_t vec(input logic act, input int wx, input int wz, input int px,
                                     input int pz, input int ph, input bit fixed,
                                     input int eh, input logic er);
    hq_vector_t v;
    v.item.act = act;
    v.item.wx = wx[COORD_W-1:0];
    v.item.wz = wz[COORD_W-1:0];
    v.item.px = px[POINT_W-1:0];
    v.item.pz = pz[POINT_W-1:0];
    v.item.ph = ph[HEIGHT_W-1:0];
    v.fixed = fixed;
    v.res.height = eh[HEIGHT_W-1:0];
    v.res.in_range = er;
    return v;
  endfunction

  function automatic void add_row(input hq_vector_t v);
    directed_vectors = {directed_vectors, v};
  endfunction

  task automatic send_item(input hq_item_t it, input bit fixed, input hq_result_t fixed_res);
    int gap;
    int idx;
    hq_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    action <= it.act;
    world_x <= it.wx;
    world_z <= it.wz;
    point_x <= it.px;
    point_z <= it.pz;
    point_height <= it.ph;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.act == ACT_WRITE) begin
      idx = int'(it.px) + int'(it.pz) * GRID_N;
      height_grid[idx] = it.ph;
      point_written[idx] = 1'b1;
    end else begin
      if (fixed) want = fixed_res;
      else want = interpolate_height(it.wx, it.wz);
      expected_heights = {expected_heights, want};
    end
  endtask

  task automatic send_query(input logic signed [COORD_W-1:0] wx,
                            input logic signed [COORD_W-1:0] wz,
                            input bit fixed, input hq_result_t fixed_res);
    int unsigned cx, cz;
    int fx, fz;
    bit okx, okz;
    hq_item_t it;
    okx = locate_cell(wx, cur_origin_x, cx, fx);
    okz = locate_cell(wz, cur_origin_z, cz, fz);
    it.wx = 24'($urandom());
    it.wz = 24'($urandom());
    // Every corner of the cell gets a height before it can be read.
    if (okx && okz) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!point_written[cx + dx + (cz + dz) * GRID_N]) begin
            it.act = ACT_WRITE;
            it.px = POINT_W'(cx + dx);
            it.pz = POINT_W'(cz + dz);
            it.ph = 16'($urandom());
            send_item(it, 1'b0, fixed_res);
          end
        end
      end
    end
    it.act = ACT_QUERY;
    it.wx = wx;
    it.wz = wz;
    it.px = 8'($urandom());
    it.pz = 8'($urandom());
    it.ph = 16'($urandom());
    send_item(it, fixed, fixed_res);
  endtask

  task automatic wait_until_drained();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (expected_heights.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_heights.size() != 0) begin
      $error("%0d expected results never arrived", expected_heights.size());
      error_count++;
      expected_heights.delete();
    end
  endtask

  task automatic write_config(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oz,
                              input logic [CFG_W-1:0] sc);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ORIGIN_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_Z;
    cfg_data <= oz;
    @(posedge clk);
    cfg_index <= CFG_GRID_SCALE;
    cfg_data <= sc;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_origin_x = ox;
    cur_origin_z = oz;
    cur_scale = sc;
  endtask

  task automatic run_random(input int count);
    hq_item_t it;
    hq_result_t none;
    int unsigned pick;
    logic signed [COORD_W-1:0] wx, wz;
    none.height = '0;
    none.in_range = 1'b0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        it.act = ACT_WRITE;
        it.wx = 24'($urandom());
        it.wz = 24'($urandom());
        it.px = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom());
        it.pz = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom());
        it.ph = 16'($urandom());
        send_item(it, 1'b0, none);
      end else begin
        if (pick < 30) begin
          wx = 24'($urandom());
          wz = 24'($urandom());
        end else if (pick < 38) begin
          wx = cur_origin_x + 24'($urandom_range(0, 4)) - 24'd2;
          wz = cur_origin_z + 24'($urandom_range(0, 4)) - 24'd2;
        end else begin
          wx = aim_axis(cur_origin_x);
          wz = aim_axis(cur_origin_z);
        end
        send_query(wx, wz, 1'b0, none);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    hq_result_t want;
    if (!rst && done) begin
      if (expected_heights.size() == 0) begin
        $error("unexpected result: height %0d in_range %0b", height, in_range);
        error_count++;
      end else begin
        want = expected_heights.pop_front();
        if (height !== want.height) begin
          $error("height: expected %0d, actual %0d", want.height, height);
          error_count++;
        end
        if (in_range !== want.in_range) begin
          $error("in_range: expected %0b, actual %0b", want.in_range, in_range);
          error_count++;
        end
      end
    end
  end

  initial begin : main_sequence
    hq_vector_t v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(vec(ACT_WRITE, 0, 0, 0, 0, 32767, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 1, 0, -32768, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 0, 1, 32767, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 1, 1, -32768, 0, 0, 0));
    add_row(vec(ACT_QUERY, 0, 0, 0, 0, 0, 1, 32767, 1));
    add_row(vec(ACT_QUERY, 256, 0, 0, 0, 0, 1, -32768, 1));
    add_row(vec(ACT_QUERY, 255, 0, 0, 0, 0, 0, 0, 0));
    add_row(vec(ACT_QUERY, 128, 128, 0, 0, 0, 0, 0, 0));
    add_row(vec(ACT_QUERY, 129, 128, 0, 0, 0, 0, 0, 0));
    add_row(vec(ACT_QUERY, 255, 255, 0, 0, 0, 0, 0, 0));
    add_row(vec(ACT_QUERY, -1, 0, 0, 0, 0, 1, 0, 0));
    add_row(vec(ACT_QUERY, 0, -8388608, 0, 0, 0, 1, 0, 0));
    add_row(vec(ACT_QUERY, 8388607, 0, 0, 0, 0, 1, 0, 0));
    add_row(vec(ACT_QUERY, 65280, 0, 0, 0, 0, 1, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 254, 0, -1, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 255, 0, 1, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 254, 1, 0, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 255, 1, -32768, 0, 0, 0));
    add_row(vec(ACT_QUERY, 65279, 0, 0, 0, 0, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 254, 254, 100, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 255, 254, -100, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 254, 255, -32768, 0, 0, 0));
    add_row(vec(ACT_WRITE, 0, 0, 255, 255, 32767, 0, 0, 0));
    add_row(vec(ACT_QUERY, 65279, 65279, 0, 0, 0, 0, 0, 0));

    foreach (directed_vectors[i]) begin
      v = directed_vectors[i];
      if (v.item.act == ACT_WRITE) send_item(v.item, 1'b0, v.res);
      else send_query(v.item.wx, v.item.wz, v.fixed, v.res);
    end

    wait_until_drained();
    write_config(24'd0, 24'd0, GRID_SCALE_RESET);
    run_random(100);

    wait_until_drained();
    write_config(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    run_random(80);

    wait_until_drained();
    write_config(24'h7FFFFF, 24'h800000, 24'd1);
    run_random(80);

    wait_until_drained();
    write_config(24'($urandom()), 24'($urandom()), 24'd0);
    run_random(40);

    for (int ph = 0; ph < 4; ph++) begin
      wait_until_drained();
      if (ph[0])
        write_config(24'($urandom()), 24'($urandom()), 24'($urandom_range(1, 24'hFFFFFF)));
      else
        write_config(24'($urandom_range(0, 8192)) - 24'd4096,
                     24'($urandom_range(0, 8192)) - 24'd4096,
                     24'($urandom_range(4096, 1 << 20)));
      run_random(100);
    end

    wait_until_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[heightfield_triangle_height_query_core.f]
hw/rtl/hfq_pkg.sv
hw/rtl/hfq_queue.sv
hw/rtl/hfq_front.sv
hw/rtl/hfq_back.sv
hw/rtl/heightfield_triangle_height_query_core.sv
tb/heightfield_triangle_height_query_core_test.sv
